@@ sv/delta_list_timer_queue_assert.svh @@
// ----------------------------------------------------------------------------
// delta list timer queue assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication
`define DLTQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define DLTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ sv/dltq_pkg.sv @@
// ----------------------------------------------------------------------------
// dltq_pkg
// sizes, codes and transfer types of the delta list timer queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dltq_pkg;

  localparam int TIMER_SLOTS = 8;
  localparam int IDX_W       = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int DELAY_W     = 24;

  typedef logic signed [DELAY_W-1:0] delay_t;

  localparam delay_t DELAY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam delay_t DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
  localparam delay_t DELAY_ONE = delay_t'(1);

  // commands
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_CHECK = 3'd1;
  localparam logic [2:0] CMD_ADD   = 3'd2;
  localparam logic [2:0] CMD_REARM = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  // result status
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  timer_id;
    logic [15:0] period;
  } in_item_t;

  typedef struct packed {
    logic       expired;
    logic [1:0] status;
    logic [3:0] active_count;
  } out_item_t;

endpackage

@@ sv/dltq_sat_addsub.sv @@
// ----------------------------------------------------------------------------
// dltq_sat_addsub
// shared saturating add/subtract unit on 24-bit signed delays
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltq_sat_addsub (
  input  dltq_pkg::delay_t a_i,
  input  dltq_pkg::delay_t b_i,
  input  logic             sub_i,
  output dltq_pkg::delay_t res_o
);

  logic [dltq_pkg::DELAY_W:0] a_ext;
  logic [dltq_pkg::DELAY_W:0] b_ext;
  logic [dltq_pkg::DELAY_W:0] sum;

  assign a_ext = {a_i[dltq_pkg::DELAY_W-1], a_i};
  assign b_ext = {b_i[dltq_pkg::DELAY_W-1], b_i};
  assign sum   = sub_i ? (a_ext - b_ext) : (a_ext + b_ext);

  // overflow when the two top bits differ
  always_comb begin
    if (sum[dltq_pkg::DELAY_W] != sum[dltq_pkg::DELAY_W-1]) begin
      res_o = sum[dltq_pkg::DELAY_W] ? dltq_pkg::DELAY_MIN : dltq_pkg::DELAY_MAX;
    end else begin
      res_o = sum[dltq_pkg::DELAY_W-1:0];
    end
  end

endmodule

@@ sv/delta_list_timer_queue.sv @@
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// sorted delta list of software timers with tick, check, add, rearm, query
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_data) carries command, timer_id, period;
//   out channel (out_valid/out_ready/out_data) returns one result per command:
//   expired flag, status and the number of queued timers after the command.
// sequence:
//   tick, check, query, ignored and refused commands: result registered
//   in the cycle after the transfer. add: scan the list to the insert
//   slot, open it by moving the later entries up, then place the new
//   entry and report. rearm: pop the head by moving the entries down,
//   hand its leftover to the new head, sum leftover and period, then
//   reinsert as an add does. the pace of each walk is set by the single
//   saturating add/subtract unit, used once per cycle, and the one
//   walking read port on the delay store.
// throughput: one command at a time; in_ready is low while an add or rearm
//   walks the list.
// reset: rst_n (sync, active low) empties the queue and clears all expired
//   flags; stores are not cleared, only occupied slots are ever read.
// stall: a result waits in the output register; a new command is taken
//   only once that register is free or being drained, and the place step
//   of an add or rearm waits the same way.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "delta_list_timer_queue_assert.svh"

module delta_list_timer_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dltq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dltq_pkg::out_item_t  out_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;  // rearm: move entries down one slot
  localparam logic [2:0] S_JOIN  = 3'd2;  // rearm: new head takes leftover
  localparam logic [2:0] S_PREP  = 3'd3;  // rearm: leftover plus period
  localparam logic [2:0] S_SCAN  = 3'd4;  // walk list subtracting deltas
  localparam logic [2:0] S_SHIFT = 3'd5;  // open the insert slot
  localparam logic [2:0] S_PLACE = 3'd6;  // write new entry, report

  // entry count of a full list
  localparam logic [dltq_pkg::CNT_W-1:0] CNT_FULL =
    dltq_pkg::CNT_W'(dltq_pkg::TIMER_SLOTS);

  // delay and id stores, one walking read address plus the head slot
  dltq_pkg::delay_t delta_mem [dltq_pkg::TIMER_SLOTS];
  logic [2:0]       id_mem    [dltq_pkg::TIMER_SLOTS];

  logic [2:0]                  state_r,  state_nxt;
  logic [dltq_pkg::CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [7:0]                  flags_r,  flags_nxt;
  logic [dltq_pkg::CNT_W-1:0]  ptr_r,    ptr_nxt;
  logic [dltq_pkg::CNT_W-1:0]  pos_r,    pos_nxt;
  dltq_pkg::delay_t            delay_r,  delay_nxt;
  dltq_pkg::delay_t            left_r,   left_nxt;
  logic [2:0]                  tid_r,    tid_nxt;
  logic [15:0]                 period_r, period_nxt;
  logic                        out_valid_r, out_valid_nxt;
  dltq_pkg::out_item_t         out_data_r,  out_data_nxt;

  logic                        in_fire;
  logic                        out_free;
  logic [dltq_pkg::CNT_W-1:0]  ptr_m1;
  logic [dltq_pkg::IDX_W-1:0]  rd_idx;
  dltq_pkg::delay_t            rd_delta;
  logic [2:0]                  rd_id;
  dltq_pkg::delay_t            head_delta;
  logic [2:0]                  head_id;
  logic                        scan_go;
  logic                        list_full;
  logic                        add_refused;
  logic                        full_reported;

  // shared unit operands
  dltq_pkg::delay_t            alu_a;
  dltq_pkg::delay_t            alu_b;
  logic                        alu_sub;
  dltq_pkg::delay_t            alu_res;

  // store write port
  logic                        wr_d_en;
  logic                        wr_i_en;
  logic [dltq_pkg::IDX_W-1:0]  wr_idx;
  dltq_pkg::delay_t            wr_delta;
  logic [2:0]                  wr_id;

  logic                        load_out;
  dltq_pkg::out_item_t         load_data;

  dltq_sat_addsub u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign list_full     = (cnt_r == CNT_FULL);
  assign add_refused   = in_fire && (in_data.command == dltq_pkg::CMD_ADD) && list_full;
  assign full_reported = out_valid_r && (out_data_r.status == dltq_pkg::STAT_FULL);

  assign ptr_m1     = ptr_r - dltq_pkg::CNT_W'(1);
  assign rd_idx     = (state_r == S_SHIFT) ? ptr_m1[dltq_pkg::IDX_W-1:0]
                                           : ptr_r[dltq_pkg::IDX_W-1:0];
  assign rd_delta   = delta_mem[rd_idx];
  assign rd_id      = id_mem[rd_idx];
  assign head_delta = delta_mem[0];
  assign head_id    = id_mem[0];

  // keep walking while the new delay reaches or passes this entry
  assign scan_go = (ptr_r < cnt_r) && (delay_r >= rd_delta);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    flags_nxt  = flags_r;
    ptr_nxt    = ptr_r;
    pos_nxt    = pos_r;
    delay_nxt  = delay_r;
    left_nxt   = left_r;
    tid_nxt    = tid_r;
    period_nxt = period_r;

    alu_a   = delay_r;
    alu_b   = rd_delta;
    alu_sub = 1'b1;

    wr_d_en  = 1'b0;
    wr_i_en  = 1'b0;
    wr_idx   = ptr_r[dltq_pkg::IDX_W-1:0];
    wr_delta = alu_res;
    wr_id    = rd_id;

    load_out  = 1'b0;
    load_data = '{expired: 1'b0, status: dltq_pkg::STAT_DONE,
                  active_count: 4'(cnt_r)};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          tid_nxt    = in_data.timer_id;
          period_nxt = in_data.period;
          unique case (in_data.command)
            dltq_pkg::CMD_TICK: begin
              // head only; saturating at the bottom of the range
              alu_a    = head_delta;
              alu_b    = dltq_pkg::DELAY_ONE;
              alu_sub  = 1'b1;
              wr_idx   = '0;
              wr_d_en  = (cnt_r != '0);
              load_out = 1'b1;
            end
            dltq_pkg::CMD_CHECK: begin
              if ((cnt_r != '0) && (head_delta <= 0)) begin
                flags_nxt[head_id] = 1'b1;
              end
              load_out = 1'b1;
            end
            dltq_pkg::CMD_ADD: begin
              if (list_full) begin
                load_data.status = dltq_pkg::STAT_FULL;
                load_out         = 1'b1;
              end else begin
                delay_nxt = dltq_pkg::delay_t'({1'b0, in_data.period});
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            dltq_pkg::CMD_REARM: begin
              if (cnt_r == '0) begin
                load_data.status = dltq_pkg::STAT_EMPTY;
                load_out         = 1'b1;
              end else begin
                left_nxt  = head_delta;
                ptr_nxt   = dltq_pkg::CNT_W'(1);
                state_nxt = S_POP;
              end
            end
            dltq_pkg::CMD_QUERY: begin
              load_data.expired        = flags_r[in_data.timer_id];
              flags_nxt[in_data.timer_id] = 1'b0;
              load_out                 = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end

      S_POP: begin
        if (ptr_r < cnt_r) begin
          wr_idx   = ptr_m1[dltq_pkg::IDX_W-1:0];
          wr_delta = rd_delta;
          wr_id    = rd_id;
          wr_d_en  = 1'b1;
          wr_i_en  = 1'b1;
          ptr_nxt  = ptr_r + dltq_pkg::CNT_W'(1);
        end else begin
          cnt_nxt   = cnt_r - dltq_pkg::CNT_W'(1);
          state_nxt = S_JOIN;
        end
      end

      S_JOIN: begin
        // follower inherits the popped head's leftover
        alu_a     = head_delta;
        alu_b     = left_r;
        alu_sub   = 1'b0;
        wr_idx    = '0;
        wr_d_en   = (cnt_r != '0);
        state_nxt = S_PREP;
      end

      S_PREP: begin
        alu_a     = left_r;
        alu_b     = dltq_pkg::delay_t'({1'b0, period_r});
        alu_sub   = 1'b0;
        delay_nxt = alu_res;
        ptr_nxt   = '0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if (scan_go) begin
          delay_nxt = alu_res;
          ptr_nxt   = ptr_r + dltq_pkg::CNT_W'(1);
        end else begin
          // fix the follower's delta, then open the slot
          alu_a   = rd_delta;
          alu_b   = delay_r;
          pos_nxt = ptr_r;
          ptr_nxt = cnt_r;
          if (ptr_r < cnt_r) begin
            wr_d_en   = 1'b1;
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_SHIFT: begin
        wr_delta = rd_delta;
        wr_id    = rd_id;
        wr_d_en  = 1'b1;
        wr_i_en  = 1'b1;
        ptr_nxt  = ptr_m1;
        if (ptr_m1 == pos_r) begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        if (out_free) begin
          wr_idx    = pos_r[dltq_pkg::IDX_W-1:0];
          wr_delta  = delay_r;
          wr_id     = tid_r;
          wr_d_en   = 1'b1;
          wr_i_en   = 1'b1;
          cnt_nxt   = cnt_r + dltq_pkg::CNT_W'(1);
          load_data.active_count = 4'(cnt_nxt);
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = load_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    pos_r      <= pos_nxt;
    delay_r    <= delay_nxt;
    left_r     <= left_nxt;
    tid_r      <= tid_nxt;
    period_r   <= period_nxt;
    out_data_r <= out_data_nxt;
  end

  // stores
  always_ff @(posedge clk) begin
    if (wr_d_en) begin
      delta_mem[wr_idx] <= wr_delta;
    end
    if (wr_i_en) begin
      id_mem[wr_idx] <= wr_id;
    end
  end

  // checks
  `DLTQ_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_FULL)
  `DLTQ_ASSERT_IMPLY(a_busy_not_ready, clk, rst_n, state_r != S_IDLE, !in_ready)
  `DLTQ_ASSERT_IMPLY(a_scan_in_range, clk, rst_n, state_r == S_SCAN, ptr_r <= cnt_r)
  `DLTQ_ASSERT_NEXT(a_full_refused, clk, rst_n, add_refused, full_reported)

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// checks the delta list timer queue against a cycle-free model of the list,
// with bursty command traffic, a stalling result side and a drain pause
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // command codes the block ignores
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_EVERY  = 120;
  localparam int TAIL_CYCLES  = 50;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  dltq_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dltq_pkg::out_item_t  out_data;

  delta_list_timer_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ------------------------------------------------------------------------
  // model of the timer list
  // ------------------------------------------------------------------------
  dltq_pkg::delay_t  list_delay [dltq_pkg::TIMER_SLOTS];
  logic [2:0]        list_id    [dltq_pkg::TIMER_SLOTS];
  int                list_len = 0;
  logic [7:0]        expiry_bits = '0;

  // command items waiting to be driven, with a flag to drain first
  dltq_pkg::in_item_t   pending_items [$];
  bit                   pending_drain [$];
  // results owed by the block, oldest first
  dltq_pkg::out_item_t  owed_results [$];

  int          accepted_total = 0;
  int          results_seen = 0;
  int          error_count = 0;

  // clamp to the signed 24-bit delay range
  function automatic longint sat_delay(longint v);
    if (v > longint'(dltq_pkg::DELAY_MAX)) return longint'(dltq_pkg::DELAY_MAX);
    if (v < longint'(dltq_pkg::DELAY_MIN)) return longint'(dltq_pkg::DELAY_MIN);
    return v;
  endfunction

  // walk the list, consume deltas, fix the follower and open a slot
  function automatic void insert_timer(logic [2:0] id, longint delay);
    int pos;
    int k;
    pos = 0;
    while (pos < list_len && delay >= longint'(list_delay[pos])) begin
      delay = sat_delay(delay - longint'(list_delay[pos]));
      pos++;
    end
    if (pos < list_len)
      list_delay[pos] =
        dltq_pkg::delay_t'(sat_delay(longint'(list_delay[pos]) - delay));
    for (k = list_len; k > pos; k--) begin
      list_delay[k] = list_delay[k-1];
      list_id[k]    = list_id[k-1];
    end
    list_delay[pos] = dltq_pkg::delay_t'(delay);
    list_id[pos]    = id;
    list_len++;
  endfunction

  // apply one command to the model and return the result it produces
  function automatic dltq_pkg::out_item_t timer_result(dltq_pkg::in_item_t item);
    dltq_pkg::out_item_t res;
    longint              leftover;
    int                  k;
    res = '0;
    res.status = dltq_pkg::STAT_DONE;
    case (item.command)
      dltq_pkg::CMD_TICK: begin
        // head stops at the most negative delay
        if (list_len > 0 && list_delay[0] != dltq_pkg::DELAY_MIN)
          list_delay[0] = list_delay[0] - dltq_pkg::DELAY_ONE;
      end
      dltq_pkg::CMD_CHECK: begin
        if (list_len > 0 && list_delay[0] <= 0)
          expiry_bits[list_id[0]] = 1'b1;
      end
      dltq_pkg::CMD_ADD: begin
        if (list_len >= dltq_pkg::TIMER_SLOTS)
          res.status = dltq_pkg::STAT_FULL;
        else
          insert_timer(item.timer_id, longint'(item.period));
      end
      dltq_pkg::CMD_REARM: begin
        if (list_len == 0) begin
          res.status = dltq_pkg::STAT_EMPTY;
        end else begin
          leftover = longint'(list_delay[0]);
          for (k = 1; k < list_len; k++) begin
            list_delay[k-1] = list_delay[k];
            list_id[k-1]    = list_id[k];
          end
          list_len--;
          // new head inherits the popped leftover, none when it was alone
          if (list_len > 0)
            list_delay[0] =
              dltq_pkg::delay_t'(sat_delay(longint'(list_delay[0]) + leftover));
          insert_timer(item.timer_id, sat_delay(leftover + longint'(item.period)));
        end
      end
      dltq_pkg::CMD_QUERY: begin
        if (expiry_bits[item.timer_id]) begin
          res.expired = 1'b1;
          expiry_bits[item.timer_id] = 1'b0;
        end
      end
      default: ;
    endcase
    res.active_count = 4'(list_len);
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // clock
  // ------------------------------------------------------------------------
  initial begin
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // command driver: bursts and gaps, optional drain before an item
  // ------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      // transfer on this edge: predict its result right away
      if (in_valid && in_ready) begin
        owed_results.push_back(timer_result(in_data));
        accepted_total++;
      end
      // channel is free for a new item after this edge
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_drain[0] && (accepted_total != results_seen ||
                                          (in_valid && in_ready))) begin
          // hold off until every owed result has been taken
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
          void'(pending_drain.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            // some bursts run back to back with no gap at all
            gap_left = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 15);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // result monitor and stall pattern of the receiver
  // ------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 100;
  int stall_left = 0;

  always @(posedge clk) begin
    dltq_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (owed_results.size() == 0) begin
          $error("result transfer with nothing owed: %p", out_data);
          error_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_data.expired !== want.expired) begin
            $error("expired mismatch: expected %0d, actual %0d",
                   want.expired, out_data.expired);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_data.status);
            error_count++;
          end
          if (out_data.active_count !== want.active_count) begin
            $error("active_count mismatch: expected %0d, actual %0d",
                   want.active_count, out_data.active_count);
            error_count++;
          end
        end
      end
      // mode 0 never stalls, mode 1 short stalls, mode 2 long stalls
      mode_left--;
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(64, 256);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (stall_mode != 0 && $urandom_range(0, 99) < 30)
          stall_left = $urandom_range(1, (stall_mode == 2) ? 25 : 3);
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus and end of run
  // ------------------------------------------------------------------------
  task automatic push_cmd(logic [2:0] cmd, logic [2:0] id, logic [15:0] period,
                          bit drain = 1'b0);
    dltq_pkg::in_item_t item;
    item.command  = cmd;
    item.timer_id = id;
    item.period   = period;
    pending_items.push_back(item);
    pending_drain.push_back(drain);
  endtask

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 12));
    if (r < 85) return 16'($urandom_range(0, 300));
    if (r < 93) return 16'($urandom);
    return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
  endfunction

  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return dltq_pkg::CMD_TICK;
    if (r < 50) return dltq_pkg::CMD_CHECK;
    if (r < 62) return dltq_pkg::CMD_ADD;
    if (r < 80) return dltq_pkg::CMD_REARM;
    if (r < 95) return dltq_pkg::CMD_QUERY;
    return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
  endfunction

  initial begin
    int n;

    // directed: empty queue cases first
    push_cmd(dltq_pkg::CMD_TICK,  3'd0, 16'd0);
    push_cmd(dltq_pkg::CMD_CHECK, 3'd0, 16'd0);
    push_cmd(dltq_pkg::CMD_REARM, 3'd4, 16'd9);       // refused, queue empty
    push_cmd(dltq_pkg::CMD_QUERY, 3'd0, 16'd0);
    push_cmd(CMD_SPARE_HI, 3'd7, 16'hffff);           // ignored command
    // zero-length timer expires on the first check
    push_cmd(dltq_pkg::CMD_ADD,   3'd5, 16'd0);
    push_cmd(dltq_pkg::CMD_CHECK, 3'd0, 16'd0);
    push_cmd(dltq_pkg::CMD_QUERY, 3'd5, 16'd0);
    push_cmd(dltq_pkg::CMD_QUERY, 3'd5, 16'd0);       // flag was cleared by the read
    push_cmd(dltq_pkg::CMD_REARM, 3'd5, 16'd3);       // lone head, no follower
    push_cmd(dltq_pkg::CMD_TICK,  3'd0, 16'd0);
    // fill the list, equal delays and both period extremes
    push_cmd(dltq_pkg::CMD_ADD,   3'd1, 16'hffff);
    push_cmd(dltq_pkg::CMD_ADD,   3'd2, 16'd10);
    push_cmd(dltq_pkg::CMD_ADD,   3'd3, 16'd10);
    push_cmd(dltq_pkg::CMD_ADD,   3'd4, 16'd0);
    push_cmd(dltq_pkg::CMD_ADD,   3'd6, 16'd100);
    push_cmd(dltq_pkg::CMD_ADD,   3'd7, 16'hffff);
    push_cmd(dltq_pkg::CMD_ADD,   3'd0, 16'd1);
    push_cmd(dltq_pkg::CMD_ADD,   3'd2, 16'd5);       // refused, queue full
    push_cmd(dltq_pkg::CMD_TICK,  3'd0, 16'd0);
    push_cmd(dltq_pkg::CMD_CHECK, 3'd0, 16'd0);
    push_cmd(dltq_pkg::CMD_REARM, 3'd3, 16'hffff);
    push_cmd(dltq_pkg::CMD_QUERY, 3'd4, 16'd0);
    push_cmd(CMD_SPARE_LO, 3'd2, 16'h5a5a);

    // random traffic, with a full drain now and then
    for (n = 0; n < RANDOM_ITEMS; n++)
      push_cmd(pick_cmd(), 3'($urandom_range(0, 7)), pick_period(),
               (n % DRAIN_EVERY) == 0);

    // single reset pulse
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all items to transfer and all results to come back
    @(posedge clk);
    while (pending_items.size() > 0 || in_valid || owed_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && owed_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
